// ===== rtl/core/hpq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; imported by every module in rtl/core.
package hpq_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int KEY_W        = 32;
    localparam int ENTRY_W      = 8;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] top_value;
        logic [ENTRY_W-1:0]      entry_count;
        status_t                 status;
    } out_t;

endpackage

// ===== rtl/core/hpq_mem.sv =====
// Key store for the heap: one write port, one read port with registered data.
// Depends on hpq_pkg.
module hpq_mem
    import hpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int ADDR_W  = $clog2(CAPACITY)
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [ADDR_W-1:0]       waddr,
    input  logic signed [KEY_W-1:0] wdata,
    input  logic                    re,
    input  logic [ADDR_W-1:0]       raddr,
    output logic signed [KEY_W-1:0] rdata
);

    logic signed [KEY_W-1:0] mem [CAPACITY];
    logic signed [KEY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hpq_seq.sv =====
// Sift sequencer: walks the heap one level at a time through a shared
// key comparator and the one-read-port key store. Depends on hpq_pkg.
module hpq_seq
    import hpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int ADDR_W  = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int NODE_W  = CNT_W + 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_t                     in_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output out_t                    res_data,
    output logic                    mem_we,
    output logic [ADDR_W-1:0]       mem_waddr,
    output logic signed [KEY_W-1:0] mem_wdata,
    output logic                    mem_re,
    output logic [ADDR_W-1:0]       mem_raddr,
    input  logic signed [KEY_W-1:0] mem_rdata
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_UP   = 10'b0000000010,
        ST_UPC  = 10'b0000000100,
        ST_LAST = 10'b0000001000,
        ST_DN   = 10'b0000010000,
        ST_DNL  = 10'b0000100000,
        ST_DNR  = 10'b0001000000,
        ST_DNC  = 10'b0010000000,
        ST_FIN  = 10'b0100000000,
        ST_RES  = 10'b1000000000
    } state_t;

    localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [NODE_W-1:0] NODE_ONE = NODE_W'(1);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [NODE_W-1:0]       hole_reg, hole_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] left_reg, left_next;
    logic signed [KEY_W-1:0] big_reg, big_next;
    logic [NODE_W-1:0]       bidx_reg, bidx_next;
    status_t                 status_reg, status_next;

    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic                    cmp_gt;
    logic [NODE_W-1:0]       count_node, left_node, right_node, parent_node;
    logic [NODE_W-1:0]       hole_m1, left_m1, right_m1, parent_m1, last_m1;
    logic [CNT_W+ENTRY_W-1:0] count_ext;

    assign cmp_gt = cmp_a > cmp_b;

    assign count_node  = {1'b0, count_reg};
    assign left_node   = {hole_reg[NODE_W-2:0], 1'b0};
    assign right_node  = {hole_reg[NODE_W-2:0], 1'b1};
    assign parent_node = {1'b0, hole_reg[NODE_W-1:1]};
    assign hole_m1     = hole_reg - NODE_ONE;
    assign left_m1     = left_node - NODE_ONE;
    assign right_m1    = right_node - NODE_ONE;
    assign parent_m1   = parent_node - NODE_ONE;
    assign last_m1     = count_node - NODE_ONE;
    assign count_ext   = {{ENTRY_W{1'b0}}, count_reg};

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        hole_next   = hole_reg;
        key_next    = key_reg;
        left_next   = left_reg;
        big_next    = big_reg;
        bidx_next   = bidx_reg;
        status_next = status_reg;
        cmp_a       = key_reg;
        cmp_b       = mem_rdata;
        mem_we      = 1'b0;
        mem_waddr   = hole_m1[ADDR_W-1:0];
        mem_wdata   = key_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        res_valid   = 1'b0;
        res_data.top_value   = (count_reg != '0) ? mem_rdata : '0;
        res_data.entry_count = count_ext[ENTRY_W-1:0];
        res_data.status      = status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    status_next = STATUS_OK;
                    if (in_data.req_type == REQ_INSERT) begin
                        if (count_reg == CAP_CNT) begin
                            status_next = STATUS_FULL;
                            state_next  = ST_FIN;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                            hole_next  = count_node + NODE_ONE;
                            key_next   = in_data.value;
                            state_next = ST_UP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = last_m1[ADDR_W-1:0];
                            count_next = count_reg - CNT_W'(1);
                            state_next = ST_LAST;
                        end
                    end
                end
            end
            ST_UP: begin
                if (hole_reg == NODE_ONE) begin
                    mem_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent_m1[ADDR_W-1:0];
                    state_next = ST_UPC;
                end
            end
            ST_UPC: begin
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata  = mem_rdata;
                    hole_next  = parent_node;
                    state_next = ST_UP;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_LAST: begin
                key_next   = mem_rdata;
                hole_next  = NODE_ONE;
                state_next = ST_DN;
            end
            ST_DN: begin
                if (left_node > count_node) begin
                    mem_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = left_m1[ADDR_W-1:0];
                    state_next = ST_DNL;
                end
            end
            ST_DNL: begin
                if (right_node <= count_node) begin
                    left_next  = mem_rdata;
                    mem_re     = 1'b1;
                    mem_raddr  = right_m1[ADDR_W-1:0];
                    state_next = ST_DNR;
                end else begin
                    big_next   = mem_rdata;
                    bidx_next  = left_node;
                    state_next = ST_DNC;
                end
            end
            ST_DNR: begin
                cmp_a = mem_rdata;
                cmp_b = left_reg;
                if (cmp_gt) begin
                    big_next  = mem_rdata;
                    bidx_next = right_node;
                end else begin
                    big_next  = left_reg;
                    bidx_next = left_node;
                end
                state_next = ST_DNC;
            end
            ST_DNC: begin
                cmp_a  = big_reg;
                cmp_b  = key_reg;
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata  = big_reg;
                    hole_next  = bidx_reg;
                    state_next = ST_DN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_RES;
            end
            ST_RES: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
        hole_reg <= hole_next;
        key_reg  <= key_next;
        left_reg <= left_next;
        big_reg  <= big_next;
        bidx_reg <= bidx_next;
    end

endmodule

// ===== rtl/core/max_heap_priority_queue_top.sv =====
// Binary max-heap priority queue, top level: key store, sift sequencer and
// the result register. Depends on hpq_pkg, hpq_mem and hpq_seq.
//
// Usage:
//   s_valid/s_ready/s_data carry one request: insert s_data.value
//   (req_type 0) or remove the maximum (req_type 1).
//   m_valid/m_ready/m_data return one result per request: the largest key
//   afterwards (0 when empty), the key count, and a status of ok, empty on
//   remove, or full on insert.
//   One request at a time; s_ready is high only while the sequencer is idle,
//   from the cycle after a result enters the output register. Steps to m_valid:
//     insert: one read and one compare per level climbed, until the root or a
//       parent stops the key; then the key is written into the hole.
//     remove: read the last key, then per level descended read the left child,
//       read the right child if there is one, pick the larger and compare it to the key.
//     every request ends by reading the root into the result; empty/full go there at once.
//   The single read port sets these steps: a sift-down level takes two reads and
//   two compares, a sift-up level one read. Reset clears the key count and
//   control state only; a slot's data is used only after it was written. When
//   m_ready is low the result holds; the next request is accepted and its result waits.
module max_heap_priority_queue_top
    import hpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    logic signed [KEY_W-1:0] mem_rdata;

    logic res_valid, res_ready;
    out_t res_data;

    logic m_valid_reg;
    out_t m_data_reg;

    hpq_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hpq_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
